@@ hw/rtl/signal_pending_mask_dispatcher_assert.svh @@
// assertion macros for the dispatcher checker
`ifndef SIGNAL_PENDING_MASK_DISPATCHER_ASSERT_SVH
`define SIGNAL_PENDING_MASK_DISPATCHER_ASSERT_SVH

// clocked check, muted while reset is held
`define SPMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define SPMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/spmd_pkg.sv @@
package spmd_pkg;

    localparam int NUM_SIGNALS = 32;

    localparam logic [4:0] SIG_KILL = 5'd9;
    localparam logic [4:0] SIG_STOP = 5'd19;
    localparam logic [31:0] KS_MASK = 32'h0008_0200;

    // operation codes
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_RAISE   = 3'd1;
    localparam logic [2:0] OP_DELIVER = 3'd2;
    localparam logic [2:0] OP_ACTION  = 3'd3;
    localparam logic [2:0] OP_MASK    = 3'd4;

    // classified commands
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_RAISE   = 3'd1;
    localparam logic [2:0] CMD_DELIVER = 3'd2;
    localparam logic [2:0] CMD_ACTION  = 3'd3;
    localparam logic [2:0] CMD_MASK    = 3'd4;
    localparam logic [2:0] CMD_ACK     = 3'd5;
    localparam logic [2:0] CMD_BAD     = 3'd6;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DISCARD = 3'd1;
    localparam logic [2:0] EV_DFL_IGN = 3'd2;
    localparam logic [2:0] EV_CONT    = 3'd3;
    localparam logic [2:0] EV_HANDLER = 3'd4;
    localparam logic [2:0] EV_TERM    = 3'd5;

    // action kinds
    localparam logic [1:0] KIND_DFL  = 2'd0;
    localparam logic [1:0] KIND_IGN  = 2'd1;
    localparam logic [1:0] KIND_FUNC = 2'd2;

    // mask update modes
    localparam logic [1:0] HOW_BLOCK   = 2'd0;
    localparam logic [1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [1:0] HOW_SET     = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  sig;
        logic        wr;
        logic [1:0]  kind;
        logic [31:0] hnd;
        logic [31:0] amask;
        logic        rflag;
        logic [1:0]  how;
        logic [31:0] mval;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  ev;
        logic [4:0]  sig;
        logic [1:0]  kind;
        logic [31:0] hnd;
        logic [31:0] amask;
        logic        rflag;
        logic [31:0] mask;
        logic        last;
    } result_t;

    // default outcome of each signal
    function automatic logic [2:0] dflt_event(input logic [4:0] s);
        logic [2:0] ev;
        case (s) inside
            5'd0, 5'd17, 5'd23, 5'd28: ev = EV_DFL_IGN;
            5'd18:                     ev = EV_CONT;
            default:                   ev = EV_TERM;
        endcase
        return ev;
    endfunction

endpackage

@@ hw/rtl/spmd_front.sv @@
module spmd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic [2:0]    operation,
    input  logic [5:0]    signal_number,
    input  logic          process_active,
    input  logic          write_enable,
    input  logic [1:0]    action_kind,
    input  logic [31:0]   handler_address,
    input  logic [31:0]   action_mask,
    input  logic          reset_on_delivery,
    input  logic [1:0]    mask_how,
    input  logic [31:0]   mask_value,
    output logic          q_valid,
    output spmd_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import spmd_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    cmd_t        c;
    logic        sig_ok;
    logic        ks;
    logic        push;

    assign sig_ok = (signal_number[5] == 1'b0) && (signal_number[4:0] != 5'd0);
    assign ks = (signal_number == {1'b0, SIG_KILL}) || (signal_number == {1'b0, SIG_STOP});

    // classify the word
    always_comb
    begin
        c       = '0;
        c.sig   = signal_number[4:0];
        c.wr    = write_enable;
        c.kind  = (action_kind == 2'd3) ? KIND_DFL : action_kind;
        c.hnd   = handler_address;
        c.amask = action_mask;
        c.rflag = reset_on_delivery;
        c.how   = mask_how;
        c.mval  = mask_value;
        case (operation)
            OP_CLEAR:   c.cmd = CMD_CLEAR;
            OP_RAISE:   c.cmd = !sig_ok ? CMD_BAD : (process_active ? CMD_RAISE : CMD_ACK);
            OP_DELIVER: c.cmd = process_active ? CMD_DELIVER : CMD_ACK;
            OP_ACTION:  c.cmd = (!sig_ok || (write_enable && ks)) ? CMD_BAD : CMD_ACTION;
            OP_MASK:    c.cmd = CMD_MASK;
            default:    c.cmd = CMD_BAD;
        endcase
    end

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_cmd      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

@@ hw/rtl/spmd_back.sv @@
module spmd_back #(
    parameter int HW = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  spmd_pkg::cmd_t   q_cmd,
    output logic             q_pop,
    output logic             result_valid,
    input  logic             result_ready,
    output spmd_pkg::result_t result
);
    import spmd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic [31:0]    pend_reg, pend_next;
    logic [31:0]    blk_reg, blk_next;
    logic [1:0]     kind_reg [NUM_SIGNALS];
    logic [1:0]     kind_next [NUM_SIGNALS];
    logic [HW-1:0]  hnd_reg [NUM_SIGNALS];
    logic [HW-1:0]  hnd_next [NUM_SIGNALS];
    logic [31:0]    am_reg [NUM_SIGNALS];
    logic [31:0]    am_next [NUM_SIGNALS];
    logic           rf_reg [NUM_SIGNALS];
    logic           rf_next [NUM_SIGNALS];
    logic           state_reg, state_next;
    logic [4:0]     idx_reg, idx_next;
    result_t        out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic           can_load;
    logic           load;
    logic [31:0]    elig;
    logic           more;
    logic           ks;
    logic [1:0]     k;
    logic           term;
    result_t        res;

    assign can_load = !out_valid_reg || result_ready;
    // pending and not blocked, kill and stop bypass the mask
    assign elig = pend_reg & (~blk_reg | KS_MASK) & 32'hFFFF_FFFE;
    assign more = |((elig >> idx_reg) >> 1);
    assign ks   = (idx_reg == SIG_KILL) || (idx_reg == SIG_STOP);
    assign k    = kind_reg[idx_reg];

    always_comb
    begin
        pend_next  = pend_reg;
        blk_next   = blk_reg;
        kind_next  = kind_reg;
        hnd_next   = hnd_reg;
        am_next    = am_reg;
        rf_next    = rf_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        res        = '0;
        load       = 1'b0;
        q_pop      = 1'b0;
        term       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_load)
                begin
                    q_pop    = 1'b1;
                    res.last = 1'b1;
                    load     = 1'b1;
                    case (q_cmd.cmd)
                        CMD_CLEAR:
                        begin
                            pend_next = '0;
                            blk_next  = '0;
                            for (int i = 0; i < NUM_SIGNALS; i++)
                            begin
                                kind_next[i] = KIND_DFL;
                                hnd_next[i]  = '0;
                                am_next[i]   = '0;
                                rf_next[i]   = 1'b0;
                            end
                        end
                        CMD_RAISE:
                        begin
                            pend_next[q_cmd.sig] = 1'b1;
                        end
                        CMD_ACK:
                        begin
                            res.status = 1'b0;
                        end
                        CMD_ACTION:
                        begin
                            res.kind  = kind_reg[q_cmd.sig];
                            res.hnd   = 32'(hnd_reg[q_cmd.sig]);
                            res.amask = am_reg[q_cmd.sig];
                            res.rflag = rf_reg[q_cmd.sig];
                            if (q_cmd.wr)
                            begin
                                kind_next[q_cmd.sig] = q_cmd.kind;
                                hnd_next[q_cmd.sig]  = q_cmd.hnd[HW-1:0];
                                am_next[q_cmd.sig]   = q_cmd.amask;
                                rf_next[q_cmd.sig]   = q_cmd.rflag;
                            end
                        end
                        CMD_MASK:
                        begin
                            res.mask = blk_reg;
                            if (q_cmd.wr)
                            begin
                                case (q_cmd.how)
                                    HOW_BLOCK:   blk_next = blk_reg | q_cmd.mval;
                                    HOW_UNBLOCK: blk_next = blk_reg & ~q_cmd.mval;
                                    HOW_SET:     blk_next = q_cmd.mval;
                                    default:     res.status = 1'b1;
                                endcase
                                blk_next = blk_next & ~KS_MASK;
                            end
                        end
                        CMD_DELIVER:
                        begin
                            if (elig != '0)
                            begin
                                load       = 1'b0;
                                state_next = ST_SCAN;
                                idx_next   = 5'd1;
                            end
                        end
                        default:
                        begin
                            res.status = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                if (!elig[idx_reg])
                begin
                    idx_next = idx_reg + 5'd1;
                end
                else if (can_load)
                begin
                    load               = 1'b1;
                    pend_next[idx_reg] = 1'b0;
                    res.sig            = idx_reg;
                    if (k == KIND_IGN && !ks)
                    begin
                        res.ev = EV_DISCARD;
                    end
                    else
                    begin
                        if (k == KIND_FUNC)
                        begin
                            res.ev  = EV_HANDLER;
                            res.hnd = 32'(hnd_reg[idx_reg]);
                        end
                        else
                        begin
                            res.ev = dflt_event(idx_reg);
                        end
                        if (k == KIND_IGN)
                        begin
                            kind_next[idx_reg] = KIND_DFL;
                        end
                        term = (res.ev == EV_TERM);
                        if (!term && rf_reg[idx_reg])
                        begin
                            kind_next[idx_reg] = KIND_DFL;
                            hnd_next[idx_reg]  = '0;
                        end
                    end
                    res.last = term || !more;
                    if (res.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
        endcase
        out_next       = load ? res : out_reg;
        out_valid_next = load || (out_valid_reg && !result_ready);
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            blk_reg       <= '0;
            state_reg     <= ST_IDLE;
            idx_reg       <= 5'd1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SIGNALS; i++)
            begin
                kind_reg[i] <= KIND_DFL;
                hnd_reg[i]  <= '0;
                am_reg[i]   <= '0;
                rf_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            pend_reg      <= pend_next;
            blk_reg       <= blk_next;
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            hnd_reg       <= hnd_next;
            am_reg        <= am_next;
            rf_reg        <= rf_next;
        end
    end

endmodule

@@ hw/rtl/signal_pending_mask_dispatcher.sv @@
// path: a control word is registered in the front queue, then its result in the back result
//   register; a delivery with signals to dispatch passes the scan state before its first result
// flow: control words and deliveries with nothing eligible are handled in the idle state;
//   any other delivery walks the signal indices up to the last one dispatched in the
//   one-signal-per-cycle table scan, holding while the result register is full
// reset: asynchronous active low, clears pending and blocked sets and the action table
module signal_pending_mask_dispatcher #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  operation,
    input  logic [5:0]  signal_number,
    input  logic        process_active,
    input  logic        write_enable,
    input  logic [1:0]  action_kind,
    input  logic [31:0] handler_address,
    input  logic [31:0] action_mask,
    input  logic        reset_on_delivery,
    input  logic [1:0]  mask_how,
    input  logic [31:0] mask_value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        status,
    output logic [2:0]  event_res,
    output logic [4:0]  signal_out,
    output logic [1:0]  action_kind_out,
    output logic [31:0] handler_out,
    output logic [31:0] action_mask_out,
    output logic        reset_out,
    output logic [31:0] mask_out,
    output logic        last
);
    import spmd_pkg::*;

    // stored handler bits: the address width, capped by the 32-bit field
    localparam int HW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    // front: classify and queue each word, a two-word queue parts it from the back
    spmd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .operation         (operation),
        .signal_number     (signal_number),
        .process_active    (process_active),
        .write_enable      (write_enable),
        .action_kind       (action_kind),
        .handler_address   (handler_address),
        .action_mask       (action_mask),
        .reset_on_delivery (reset_on_delivery),
        .mask_how          (mask_how),
        .mask_value        (mask_value),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .q_pop             (q_pop)
    );

    // back: state, action table, delivery scan and result register
    spmd_back #(
        .HW (HW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (res)
    );

    // unpack result word onto ports
    assign status          = res.status;
    assign event_res       = res.ev;
    assign signal_out      = res.sig;
    assign action_kind_out = res.kind;
    assign handler_out     = res.hnd;
    assign action_mask_out = res.amask;
    assign reset_out       = res.rflag;
    assign mask_out        = res.mask;
    assign last            = res.last;

endmodule

@@ hw/rtl/spmd_checker.sv @@
`include "signal_pending_mask_dispatcher_assert.svh"

module spmd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic       status,
    input logic [2:0] event_res,
    input logic [4:0] signal_out,
    input logic       last
);
    import spmd_pkg::*;

    `SPMD_ASSERT(a_hold, result_valid && !result_ready |=> result_valid, "result dropped")
    `SPMD_ASSERT(a_term_last, result_valid && event_res == EV_TERM |-> last, "terminate not last")
    `SPMD_ASSERT(a_err_single, result_valid && status |-> last && event_res == EV_NONE, "bad error word")
    `SPMD_ASSERT_ALWAYS(a_ev_sig, !rst_n || !result_valid || event_res == EV_NONE || (signal_out != 5'd0 && !status), "event without signal")

endmodule

bind signal_pending_mask_dispatcher spmd_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .event_res    (event_res),
    .signal_out   (signal_out),
    .last         (last)
);

@@ verif/testbench.sv @@
module testbench;
    import spmd_pkg::*;

    // one expected result word from the dispatcher
    typedef struct {
        logic        status;
        logic [2:0]  ev;
        logic [4:0]  sig;
        logic [1:0]  kind;
        logic [31:0] hnd;
        logic [31:0] amask;
        logic        rflag;
        logic [31:0] mask;
        logic        last;
    } disp_word_t;

    // software copy of the dispatcher state plus the queue of results still owed
    class dispatch_scoreboard;
        logic [31:0] pending;
        logic [31:0] blocked;
        logic [1:0]  kind_tab [32];
        logic [31:0] hnd_tab [32];
        logic [31:0] amask_tab [32];
        logic        rflag_tab [32];
        disp_word_t  owed [$];
        int          errors;
        int          words_checked;
        int          deliveries;

        function void clear_state();
            pending = '0;
            blocked = '0;
            for (int i = 0; i < 32; i++)
            begin
                kind_tab[i] = KIND_DFL;
                hnd_tab[i] = '0;
                amask_tab[i] = '0;
                rflag_tab[i] = 1'b0;
            end
        endfunction

        function void push(logic st, logic [2:0] ev, logic [4:0] s, logic [1:0] k,
                           logic [31:0] h, logic [31:0] am, logic rf,
                           logic [31:0] mk, logic lst);
            disp_word_t w;
            w.status = st; w.ev = ev; w.sig = s; w.kind = k; w.hnd = h;
            w.amask = am; w.rflag = rf; w.mask = mk; w.last = lst;
            owed.push_back(w);
        endfunction

        function logic [2:0] default_outcome(int s);
            if (s == 0 || s == 17 || s == 23 || s == 28) return EV_DFL_IGN;
            if (s == 18) return EV_CONT;
            return EV_TERM;
        endfunction

        // scan pending signals in ascending order
        function void scan_pending();
            int n;
            logic [2:0] ev;
            logic [31:0] h;
            n = 0;
            deliveries++;
            for (int s = 1; s < 32; s++)
            begin
                if (!pending[s]) continue;
                if (s != SIG_KILL && s != SIG_STOP && blocked[s]) continue;
                pending[s] = 1'b0;
                if (kind_tab[s] == KIND_IGN)
                begin
                    if (s == SIG_KILL || s == SIG_STOP)
                        kind_tab[s] = KIND_DFL;
                    else
                    begin
                        push(0, EV_DISCARD, s, 0, 0, 0, 0, 0, 0);
                        n++;
                        continue;
                    end
                end
                h = '0;
                if (kind_tab[s] == KIND_FUNC)
                begin
                    ev = EV_HANDLER;
                    h = hnd_tab[s];
                end
                else
                    ev = default_outcome(s);
                if (ev == EV_TERM)
                begin
                    push(0, ev, s, 0, 0, 0, 0, 0, 1);
                    return;
                end
                push(0, ev, s, 0, h, 0, 0, 0, 0);
                n++;
                if (rflag_tab[s])
                begin
                    kind_tab[s] = KIND_DFL;
                    hnd_tab[s] = '0;
                end
            end
            if (n == 0)
                push(0, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
            else
                owed[$].last = 1'b1;
        endfunction

        function void note_word(logic [2:0] op, logic [5:0] sn, logic act, logic wr,
                                logic [1:0] ak, logic [31:0] ha, logic [31:0] am,
                                logic rod, logic [1:0] how, logic [31:0] mv);
            logic ok;
            logic [31:0] old;
            logic st;
            ok = (sn >= 1 && sn < 32);
            case (op)
                OP_CLEAR:
                begin
                    clear_state();
                    push(0, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
                end
                OP_RAISE:
                begin
                    if (!ok)
                        push(1, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        if (act) pending[sn] = 1'b1;
                        push(0, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                OP_DELIVER:
                begin
                    if (!act)
                        push(0, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
                    else
                        scan_pending();
                end
                OP_ACTION:
                begin
                    if (!ok || (wr && (sn == SIG_KILL || sn == SIG_STOP)))
                        push(1, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        push(0, EV_NONE, 0, kind_tab[sn], hnd_tab[sn], amask_tab[sn],
                             rflag_tab[sn], 0, 1);
                        if (wr)
                        begin
                            kind_tab[sn] = (ak == 2'd3) ? KIND_DFL : ak;
                            hnd_tab[sn] = ha;
                            amask_tab[sn] = am;
                            rflag_tab[sn] = rod;
                        end
                    end
                end
                OP_MASK:
                begin
                    old = blocked;
                    st = 1'b0;
                    if (wr)
                    begin
                        if (how == HOW_BLOCK) blocked = blocked | mv;
                        else if (how == HOW_UNBLOCK) blocked = blocked & ~mv;
                        else if (how == HOW_SET) blocked = mv;
                        else st = 1'b1;
                        blocked = blocked & ~KS_MASK;
                    end
                    push(st, EV_NONE, 0, 0, 0, 0, 0, old, 1);
                end
                default: push(1, EV_NONE, 0, 0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_word(disp_word_t got);
            disp_word_t w;
            words_checked++;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result word st=%0d ev=%0d sig=%0d", $time,
                         got.status, got.ev, got.sig);
                errors++;
                return;
            end
            w = owed.pop_front();
            if (got.status !== w.status)
            begin
                $display("%0t: status expected %0h actual %0h", $time, w.status, got.status);
                errors++;
            end
            if (got.ev !== w.ev)
            begin
                $display("%0t: event_res expected %0h actual %0h", $time, w.ev, got.ev);
                errors++;
            end
            if (got.sig !== w.sig)
            begin
                $display("%0t: signal_out expected %0h actual %0h", $time, w.sig, got.sig);
                errors++;
            end
            if (got.kind !== w.kind)
            begin
                $display("%0t: action_kind_out expected %0h actual %0h", $time, w.kind,
                         got.kind);
                errors++;
            end
            if (got.hnd !== w.hnd)
            begin
                $display("%0t: handler_out expected %0h actual %0h", $time, w.hnd, got.hnd);
                errors++;
            end
            if (got.amask !== w.amask)
            begin
                $display("%0t: action_mask_out expected %0h actual %0h", $time, w.amask,
                         got.amask);
                errors++;
            end
            if (got.rflag !== w.rflag)
            begin
                $display("%0t: reset_out expected %0h actual %0h", $time, w.rflag, got.rflag);
                errors++;
            end
            if (got.mask !== w.mask)
            begin
                $display("%0t: mask_out expected %0h actual %0h", $time, w.mask, got.mask);
                errors++;
            end
            if (got.last !== w.last)
            begin
                $display("%0t: last expected %0h actual %0h", $time, w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [2:0]  operation;
    logic [5:0]  signal_number;
    logic        process_active;
    logic        write_enable;
    logic [1:0]  action_kind;
    logic [31:0] handler_address;
    logic [31:0] action_mask;
    logic        reset_on_delivery;
    logic [1:0]  mask_how;
    logic [31:0] mask_value;
    logic        result_valid;
    logic        result_ready;
    logic        status;
    logic [2:0]  event_res;
    logic [4:0]  signal_out;
    logic [1:0]  action_kind_out;
    logic [31:0] handler_out;
    logic [31:0] action_mask_out;
    logic        reset_out;
    logic [31:0] mask_out;
    logic        last;

    dispatch_scoreboard sb;
    int  idle_cycles;          // cycles since anything was accepted
    bit  sink_calm;            // receiver never stalls in the final part
    bit  sink_hold_req;        // ask the receiver for one long hold-off
    int  words_sent;

    signal_pending_mask_dispatcher dut (.*);

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // every input at a known value before reset lets go
    initial
    begin
        sb = new();
        sb.clear_state();
        rst_n = 1'b0;
        item_valid = 1'b0;
        operation = '0;
        signal_number = '0;
        process_active = 1'b0;
        write_enable = 1'b0;
        action_kind = '0;
        handler_address = '0;
        action_mask = '0;
        reset_on_delivery = 1'b0;
        mask_how = '0;
        mask_value = '0;
        result_ready = 1'b0;
        sink_calm = 1'b0;
        sink_hold_req = 1'b0;
        words_sent = 0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: check every accepted word, sampling the values held at the edge
    always @(posedge clk)
    begin
        disp_word_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got.status = status; got.ev = event_res; got.sig = signal_out;
            got.kind = action_kind_out; got.hnd = handler_out;
            got.amask = action_mask_out; got.rflag = reset_out;
            got.mask = mask_out; got.last = last;
            sb.check_word(got);
        end
    end

    // receiver stalls: random bursts, one long hold-off on request, none at the end
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_req)
            begin
                result_ready <= 1'b0;
                repeat (150) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 15);
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 20);
                result_ready <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    // watchdog on accepted handshakes
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one word and hold it until accepted, then note it in the scoreboard
    task automatic send_word(logic [2:0] op, logic [5:0] sn, logic act, logic wr,
                             logic [1:0] ak, logic [31:0] ha, logic [31:0] am,
                             logic rod, logic [1:0] how, logic [31:0] mv);
        item_valid <= 1'b1;
        operation <= op;
        signal_number <= sn;
        process_active <= act;
        write_enable <= wr;
        action_kind <= ak;
        handler_address <= ha;
        action_mask <= am;
        reset_on_delivery <= rod;
        mask_how <= how;
        mask_value <= mv;
        do @(posedge clk); while (!item_ready);
        sb.note_word(op, sn, act, wr, ak, ha, am, rod, how, mv);
        words_sent++;
    endtask

    // sender gap between words, lowering valid only when a gap is taken
    task automatic maybe_gap();
        int n;
        if (!sink_calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 15);
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic raise(int s);
        send_word(OP_RAISE, s, 1, 0, 0, $urandom, $urandom, 0, 0, $urandom);
    endtask

    task automatic deliver_now();
        send_word(OP_DELIVER, $urandom_range(0, 63), 1, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic set_action(int s, logic [1:0] k, logic rf);
        send_word(OP_ACTION, s, $urandom, 1, k, $urandom, $urandom, rf, 0, $urandom);
    endtask

    // random word, mostly well-formed with a bias toward raise and deliver
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_word(OP_RAISE, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                      : $urandom_range(1, 31), $urandom_range(0, 9) != 0, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 55)
            send_word(OP_DELIVER, $urandom, $urandom_range(0, 9) != 0, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 75)
            send_word(OP_ACTION, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                      : $urandom_range(1, 31), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        else if (pick < 92)
            send_word(OP_MASK, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom & $urandom);
        else if (pick < 96)
            send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        else
            send_word($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // stimulus
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);

        // directed: empty delivery, bad signals, every op, field extremes
        deliver_now();
        send_word(OP_RAISE, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_RAISE, 32, 1, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_RAISE, 63, 1, 1, 3, '1, '1, 1, 3, '1);
        send_word(OP_RAISE, 5, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_DELIVER, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // raises with every default outcome; each delivery stops at a terminating signal (1, then 2)
        raise(17); raise(18); raise(28); raise(31); raise(2); raise(1);
        deliver_now();
        deliver_now();
        // action table: bad index, write to kill/stop, code three, handler with reset flag
        send_word(OP_ACTION, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_ACTION, SIG_KILL, 1, 1, KIND_FUNC, 32'h1234, 0, 0, 0, 0);
        send_word(OP_ACTION, 12, 1, 1, 3, '1, '1, 1, 0, 0);
        send_word(OP_ACTION, 12, 1, 0, 0, 0, 0, 0, 0, 0);
        set_action(10, KIND_FUNC, 1);
        set_action(11, KIND_IGN, 1);
        raise(10); raise(11); raise(SIG_KILL);
        // mask: set with kill/stop bits, invalid how, unblock, read
        send_word(OP_MASK, 0, 1, 1, 0, 0, 0, 0, HOW_SET, '1);
        send_word(OP_MASK, 0, 1, 1, 0, 0, 0, 0, 2'd3, 32'h5);
        raise(SIG_STOP);
        deliver_now();
        send_word(OP_MASK, 0, 1, 1, 0, 0, 0, 0, HOW_UNBLOCK, 32'h0000_1c00);
        deliver_now();
        send_word(OP_MASK, 0, 1, 0, 0, 0, 0, 0, HOW_BLOCK, 0);
        send_word(3'd7, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // long receiver hold-off while words keep coming
        sink_hold_req = 1'b1;
        for (int i = 0; i < 12; i++) random_word();
        // sender pause until everything owed has come
        wait_drained();

        // random traffic, with scripted bursts of raises then a delivery
        while (words_sent < 300)
        begin
            if (words_sent > 265) sink_calm = 1'b1;
            if ($urandom_range(0, 5) == 0)
            begin
                int k;
                k = $urandom_range(2, 10);
                for (int j = 0; j < k; j++) raise($urandom_range(1, 31));
                if ($urandom_range(0, 1) == 0) set_action($urandom_range(1, 31),
                                                          $urandom_range(0, 3), $urandom);
                deliver_now();
            end
            else
                random_word();
            maybe_gap();
        end
        item_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("covered %0d input words, %0d deliveries, %0d result words checked",
                 words_sent, sb.deliveries, sb.words_checked);
        $display("raise, deliver, action and mask access, clear and bad codes under stalls");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
